// ----- src/htrp_pkg.sv -----
// Package for the display touch/text receive parser: constants, codes and shared types.
package htrp_pkg;

   // Default size of the text buffer, counted in characters plus one.
   localparam int TEXT_CAPACITY = 32;

   // Byte codes seen on the display link
   localparam logic [7:0] HDR_BYTE    = 8'h65;
   localparam logic [7:0] TRAIL_BYTE  = 8'hFF;
   localparam logic [7:0] PRINT_LO    = 8'h20;
   localparam logic [7:0] PRINT_HI    = 8'h7E;
   localparam logic [7:0] LF_BYTE     = 8'h0A;
   localparam logic [7:0] CR_BYTE     = 8'h0D;

   // Result kinds
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_TEXT  = 1'b1;

   // Frame parser phase
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DATA0  = 3'd1,
      PH_DATA1  = 3'd2,
      PH_DATA2  = 3'd3,
      PH_TRAIL0 = 3'd4,
      PH_TRAIL1 = 3'd5,
      PH_TRAIL2 = 3'd6
   } phase_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_READ = 2'd1,
      ST_LOAD = 2'd2
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take_byte;   // request accepted this cycle
      logic text_read;   // read the text buffer at the run index
      logic text_load;   // move the read character into the output register
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic starts_run;  // the pending request ends a non-empty text
      logic out_free;    // the output register can take a result this cycle
      logic run_last;    // run index points at the final stored character
   } dp_status_type;

endpackage

// ----- src/htrp_if.sv -----
// Channel interfaces: request bytes, results and the enable register write.

interface htrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface htrp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] event_page;
   logic [7:0] event_component;
   logic [7:0] event_action;
   logic [6:0] text_char;
   logic       last;
   modport source (output valid, output kind, output event_page, output event_component,
                   output event_action, output text_char, output last, input ready);
   modport sink   (input valid, input kind, input event_page, input event_component,
                   input event_action, input text_char, input last, output ready);
endinterface

interface htrp_csr_if;
   logic valid;
   logic ready;
   logic enable;
   modport source (output valid, output enable, input ready);
   modport sink   (input valid, input enable, output ready);
endinterface

// ----- src/htrp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module htrp_ram #(
   parameter int WIDTH  = 7,
   parameter int DEPTH  = 31,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/htrp_ctrl.sv -----
// Controller: accepts requests and sequences the emission of a stored text run.
module htrp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  htrp_pkg::dp_status_type status,
   output htrp_pkg::ctl_cmd_type   cmd
);

   htrp_pkg::ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htrp_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.take_byte  = 1'b0;
      cmd.text_read  = 1'b0;
      cmd.text_load  = 1'b0;
      unique case (state_ff)
         htrp_pkg::ST_RUN: begin
            req_ready     = status.out_free;
            cmd.take_byte = req_valid && status.out_free;
            if (cmd.take_byte && status.starts_run) begin
               state_in = htrp_pkg::ST_READ;
            end
         end
         htrp_pkg::ST_READ: begin
            cmd.text_read = 1'b1;
            state_in      = htrp_pkg::ST_LOAD;
         end
         htrp_pkg::ST_LOAD: begin
            // hold the read character until the output register frees up
            if (status.out_free) begin
               cmd.text_load = 1'b1;
               state_in      = status.run_last ? htrp_pkg::ST_RUN : htrp_pkg::ST_READ;
            end
         end
         default: begin
            state_in = htrp_pkg::ST_RUN;
         end
      endcase
   end

endmodule

// ----- src/htrp_datapath.sv -----
// Datapath: frame parser, text buffer, enable register and output register.
module htrp_datapath #(
   parameter int TEXT_CAPACITY = htrp_pkg::TEXT_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              rx_byte,
   input  logic                    csr_write,
   input  logic                    csr_enable,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_page,
   output logic [7:0]              rsp_component,
   output logic [7:0]              rsp_action,
   output logic [6:0]              rsp_char,
   output logic                    rsp_last,
   input  htrp_pkg::ctl_cmd_type   cmd,
   output htrp_pkg::dp_status_type status
);

   localparam int DEPTH  = TEXT_CAPACITY - 1;
   localparam int LEN_W  = $clog2(TEXT_CAPACITY);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);

   logic                 enable_ff;
   htrp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           ev_page_ff, ev_comp_ff, ev_act_ff;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [ADDR_W-1:0]    idx_ff;
   logic                 out_valid_ff;
   logic                 out_kind_ff, out_last_ff;
   logic [7:0]           out_page_ff, out_comp_ff, out_act_ff;
   logic [6:0]           out_char_ff;

   logic                 active;
   logic                 printable, eol;
   logic                 ev_done;
   logic                 buf_wr;
   logic [6:0]           rd_char;

   // Byte classification
   assign active    = cmd.take_byte && enable_ff;
   assign printable = (rx_byte >= htrp_pkg::PRINT_LO) && (rx_byte <= htrp_pkg::PRINT_HI);
   assign eol       = (rx_byte == htrp_pkg::LF_BYTE) || (rx_byte == htrp_pkg::CR_BYTE);

   // Status to the controller
   assign status.starts_run = enable_ff && (phase_ff == htrp_pkg::PH_IDLE) && eol
                              && (len_ff != '0);
   assign status.out_free   = !out_valid_ff || rsp_ready;
   assign status.run_last   = (LEN_W'(idx_ff) == (len_ff - 1'b1));

   // Frame parser and text length next state
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      ev_done  = 1'b0;
      buf_wr   = 1'b0;
      if (active) begin
         unique case (phase_ff)
            htrp_pkg::PH_DATA0: phase_in = htrp_pkg::PH_DATA1;
            htrp_pkg::PH_DATA1: phase_in = htrp_pkg::PH_DATA2;
            htrp_pkg::PH_DATA2: phase_in = htrp_pkg::PH_TRAIL0;
            htrp_pkg::PH_TRAIL0: begin
               phase_in = (rx_byte == htrp_pkg::TRAIL_BYTE) ? htrp_pkg::PH_TRAIL1
                                                            : htrp_pkg::PH_IDLE;
            end
            htrp_pkg::PH_TRAIL1: begin
               phase_in = (rx_byte == htrp_pkg::TRAIL_BYTE) ? htrp_pkg::PH_TRAIL2
                                                            : htrp_pkg::PH_IDLE;
            end
            htrp_pkg::PH_TRAIL2: begin
               phase_in = htrp_pkg::PH_IDLE;
               ev_done  = (rx_byte == htrp_pkg::TRAIL_BYTE);
            end
            default: begin
               phase_in = htrp_pkg::PH_IDLE;
               if (rx_byte == htrp_pkg::HDR_BYTE) begin
                  phase_in = htrp_pkg::PH_DATA0;
               end else if (printable) begin
                  if (len_ff < LEN_MAX) begin
                     buf_wr = 1'b1;
                     len_in = len_ff + 1'b1;
                  end
               end
            end
         endcase
      end
      // a run empties the buffer once its final character is loaded
      if (cmd.text_load && status.run_last) begin
         len_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         phase_ff     <= htrp_pkg::PH_IDLE;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            enable_ff <= csr_enable;
         end
         phase_ff <= phase_in;
         len_ff   <= len_in;
         if (ev_done || cmd.text_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Event bytes, run index and output payload
   always_ff @(posedge clock) begin
      if (active) begin
         case (phase_ff)
            htrp_pkg::PH_DATA0: ev_page_ff <= rx_byte;
            htrp_pkg::PH_DATA1: ev_comp_ff <= rx_byte;
            htrp_pkg::PH_DATA2: ev_act_ff  <= rx_byte;
            default: ;
         endcase
      end
      if (cmd.take_byte) begin
         idx_ff <= '0;
      end else if (cmd.text_load) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (ev_done) begin
         out_kind_ff <= htrp_pkg::KIND_EVENT;
         out_page_ff <= ev_page_ff;
         out_comp_ff <= ev_comp_ff;
         out_act_ff  <= ev_act_ff;
         out_char_ff <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.text_load) begin
         out_kind_ff <= htrp_pkg::KIND_TEXT;
         out_page_ff <= '0;
         out_comp_ff <= '0;
         out_act_ff  <= '0;
         out_char_ff <= rd_char;
         out_last_ff <= status.run_last;
      end
   end

   // Text buffer
   htrp_ram #(
      .WIDTH  (7),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (rx_byte[6:0]),
      .rd_en   (cmd.text_read),
      .rd_addr (idx_ff),
      .rd_data (rd_char)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_page      = out_page_ff;
   assign rsp_component = out_comp_ff;
   assign rsp_action    = out_act_ff;
   assign rsp_char      = out_char_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ----- src/hmi_touch_and_text_rx_parser_top.sv -----
// Top level of the display receive parser: touch-event frames and text lines.
//
// Channels: req_bus carries one received byte per request; rsp_bus carries
// results (kind 0 = touch event with page/component/action, kind 1 = one
// text character, last set on the final character of a line and on every
// event); csr_bus writes the enable bit, always ready. Write it while idle.
// The closing trailer byte of a frame loads its event into the output register at
// the edge that accepts it, so the event is offered from the next cycle. A CR
// or LF ending a non-empty text holds off requests while the characters are
// read out of the text RAM, each by a RAM read and then a load of the output
// register. Throughput is one byte per cycle otherwise, as long as the output
// register is free to take a result.
// Reset clears enable, the frame phase and the text length; the text RAM is
// not cleared. When the receiver stalls with a result pending, req_ready and
// the text readout wait until the output register is taken.
module hmi_touch_and_text_rx_parser_top #(
   parameter int TEXT_CAPACITY = htrp_pkg::TEXT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   htrp_req_if.sink    req_bus,
   htrp_rsp_if.source  rsp_bus,
   htrp_csr_if.sink    csr_bus
);

   htrp_pkg::ctl_cmd_type   cmd;
   htrp_pkg::dp_status_type status;

   assign csr_bus.ready = 1'b1;

   // Request and readout sequencing
   htrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Parser, text buffer and output register
   htrp_datapath #(
      .TEXT_CAPACITY (TEXT_CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_bus.rx_byte),
      .csr_write     (csr_bus.valid),
      .csr_enable    (csr_bus.enable),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_kind      (rsp_bus.kind),
      .rsp_page      (rsp_bus.event_page),
      .rsp_component (rsp_bus.event_component),
      .rsp_action    (rsp_bus.event_action),
      .rsp_char      (rsp_bus.text_char),
      .rsp_last      (rsp_bus.last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

// ----- tb/hmi_touch_and_text_rx_parser_top_tb.sv -----
// Testbench for the display receive parser: random and directed bytes, scoreboard checks.
`timescale 1ns / 1ps

module hmi_touch_and_text_rx_parser_top_tb;

   localparam int LINE_MAX    = htrp_pkg::TEXT_CAPACITY - 1;
   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_WAIT  = 2 * LINE_MAX + 8;

   typedef struct packed {
      logic       kind;
      logic [7:0] page;
      logic [7:0] component;
      logic [7:0] action;
      logic [6:0] text_char;
      logic       last;
   } parser_result_type;

   // Shadow of the parser state plus the queue of results still owed
   class parser_scoreboard;
      logic                string_unused_guard = 1'b0;
      logic                enabled    = 1'b0;
      htrp_pkg::phase_type phase      = htrp_pkg::PH_IDLE;
      logic [7:0]          frame_data [3];
      logic [1:0]          trail_seen = 2'd0;
      logic [6:0]          line_buf   [LINE_MAX];
      int                  line_len   = 0;
      parser_result_type   pending    [$];
      int                  errors     = 0;

      // Advance the shadow parser by one accepted request
      function void note_request(logic [7:0] b);
         parser_result_type r;
         if (!enabled) return;
         r = '0;
         case (phase)
            htrp_pkg::PH_DATA0, htrp_pkg::PH_DATA1, htrp_pkg::PH_DATA2: begin
               frame_data[int'(phase) - 1] = b;
               phase = htrp_pkg::phase_type'(phase + 3'd1);
            end
            htrp_pkg::PH_TRAIL0, htrp_pkg::PH_TRAIL1, htrp_pkg::PH_TRAIL2: begin
               if (b == htrp_pkg::TRAIL_BYTE) begin
                  trail_seen = trail_seen + 2'd1;
                  if (trail_seen == 2'd3) begin
                     r.kind      = htrp_pkg::KIND_EVENT;
                     r.page      = frame_data[0];
                     r.component = frame_data[1];
                     r.action    = frame_data[2];
                     r.last      = 1'b1;
                     pending.push_back(r);
                     phase = htrp_pkg::PH_IDLE;
                  end else begin
                     phase = htrp_pkg::phase_type'(phase + 3'd1);
                  end
               end else begin
                  // bad trailer: frame dropped, byte consumed
                  phase = htrp_pkg::PH_IDLE;
               end
            end
            default: begin
               phase = htrp_pkg::PH_IDLE;
               if (b == htrp_pkg::HDR_BYTE) begin
                  phase      = htrp_pkg::PH_DATA0;
                  trail_seen = 2'd0;
               end else if (b >= htrp_pkg::PRINT_LO && b <= htrp_pkg::PRINT_HI) begin
                  if (line_len < LINE_MAX) begin
                     line_buf[line_len] = b[6:0];
                     line_len++;
                  end
               end else if ((b == htrp_pkg::LF_BYTE || b == htrp_pkg::CR_BYTE)
                            && line_len > 0) begin
                  for (int i = 0; i < line_len; i++) begin
                     r.kind      = htrp_pkg::KIND_TEXT;
                     r.text_char = line_buf[i];
                     r.last      = (i + 1 == line_len);
                     pending.push_back(r);
                  end
                  line_len = 0;
               end
            end
         endcase
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(parser_result_type got);
         parser_result_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display({"ERROR %0t: unexpected result kind=%0b page=%02h comp=%02h",
                         " act=%02h char=%02h last=%0b"},
                        $realtime, got.kind, got.page, got.component, got.action,
                        got.text_char, got.last);
            return;
         end
         exp = pending.pop_front();
         if (got.kind != exp.kind || got.page != exp.page || got.component != exp.component ||
             got.action != exp.action || got.text_char != exp.text_char ||
             got.last != exp.last) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR %0t: result mismatch", $realtime);
               $display("   expected kind=%0b page=%02h comp=%02h act=%02h char=%02h last=%0b",
                        exp.kind, exp.page, exp.component, exp.action, exp.text_char, exp.last);
               $display("   actual   kind=%0b page=%02h comp=%02h act=%02h char=%02h last=%0b",
                        got.kind, got.page, got.component, got.action, got.text_char, got.last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   htrp_req_if req_bus ();
   htrp_rsp_if rsp_bus ();
   htrp_csr_if csr_bus ();

   hmi_touch_and_text_rx_parser_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   parser_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_seq       = 0;
   int bytes_sent     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Monitor and watchdog: sample handshakes at each edge
   initial begin : monitor
      int quiet;
      parser_result_type got;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            quiet++;
            if (csr_bus.valid && csr_bus.ready) begin
               sb.enabled = csr_bus.enable;
               quiet = 0;
            end
            if (req_bus.valid && req_bus.ready) begin
               sb.note_request(req_bus.rx_byte);
               quiet = 0;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               got.kind      = rsp_bus.kind;
               got.page      = rsp_bus.event_page;
               got.component = rsp_bus.event_component;
               got.action    = rsp_bus.event_action;
               got.text_char = rsp_bus.text_char;
               got.last      = rsp_bus.last;
               sb.check_result(got);
               quiet = 0;
            end
            if (quiet >= IDLE_LIMIT) begin
               $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                        IDLE_LIMIT, sb.pending.size());
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   // Offer one byte, with random sender gaps, and wait until it is taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] page, input logic [7:0] comp,
                             input logic [7:0] act);
      send_byte(htrp_pkg::HDR_BYTE);
      send_byte(page);
      send_byte(comp);
      send_byte(act);
      repeat (3) send_byte(htrp_pkg::TRAIL_BYTE);
   endtask

   task automatic send_text(input int len, input logic [7:0] term);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(htrp_pkg::PRINT_HI, htrp_pkg::PRINT_LO)));
      send_byte(term);
   endtask

   // Let the block drain before touching the enable register
   task automatic settle();
      req_bus.valid <= 1'b0;
      // let the monitor note the last accepted request before the queue is checked
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      settle();
      csr_bus.valid  <= 1'b1;
      csr_bus.enable <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly well-formed frames and lines with random content, some noise
   task automatic run_random(input int budget);
      int stop;
      int pick;
      int k;
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 75) begin
            k = ($urandom_range(9) == 0) ? $urandom_range(36, 20) : $urandom_range(6, 0);
            send_text(k, $urandom_range(1) ? htrp_pkg::CR_BYTE : htrp_pkg::LF_BYTE);
         end else if (pick < 88) begin
            send_byte(htrp_pkg::HDR_BYTE);
            repeat (3) send_byte(8'($urandom));
            k = $urandom_range(2);
            repeat (k) send_byte(htrp_pkg::TRAIL_BYTE);
            send_byte(8'($urandom));
         end else begin
            send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // Main sequence
   initial begin
      sb = new;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.enable  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: bytes are taken but ignored
      send_text(3, htrp_pkg::LF_BYTE);
      send_frame(8'h01, 8'h02, 8'h03);
      write_enable(1'b1);

      // directed: data extremes, text edges, empty terminators, ignored bytes
      send_frame(8'h00, 8'h00, 8'h00);
      send_frame(8'hFF, 8'hFF, 8'hFF);
      send_byte(htrp_pkg::PRINT_LO);
      send_byte(htrp_pkg::PRINT_HI);
      send_byte(htrp_pkg::CR_BYTE);
      send_byte(htrp_pkg::LF_BYTE);
      send_byte(htrp_pkg::CR_BYTE);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      // text kept across a frame
      send_byte("x");
      send_frame(8'h12, 8'h34, 8'h56);
      send_byte("y");
      send_byte(htrp_pkg::LF_BYTE);
      // bad trailer byte is swallowed, not collected as text
      send_byte(htrp_pkg::HDR_BYTE);
      send_byte(8'h0A);
      send_byte(8'h0D);
      send_byte(htrp_pkg::HDR_BYTE);
      send_byte(htrp_pkg::TRAIL_BYTE);
      send_byte("A");
      send_byte("z");
      send_byte(htrp_pkg::LF_BYTE);
      // header inside a line starts a frame
      send_byte("q");
      send_frame(8'h07, 8'h08, 8'h09);
      send_byte(htrp_pkg::CR_BYTE);
      // overflow: only LINE_MAX characters kept
      send_text(LINE_MAX + 1, htrp_pkg::CR_BYTE);

      run_random(12);

      // disable: state must hold while bytes are ignored
      write_enable(1'b0);
      send_byte("m");
      run_random(4);
      write_enable(1'b1);

      // sender gaps
      send_idle_pct = 60;
      run_random(12);

      // receiver stalls, with one long hold-off that backs up the input
      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 60;
      hold_seq++;
      send_text(4, htrp_pkg::LF_BYTE);
      send_frame(8'hA5, 8'h5A, 8'hC3);
      run_random(8);

      // both sides idle now and then
      send_idle_pct  = 17;
      recv_stall_pct = 17;
      run_random(10);

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.errors++;
         $display("ERROR: %0d expected results never arrived", sb.pending.size());
      end
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
